### hdl/sndx_pkg.sv
// Shared types, character constants and the soundex letter table.
`timescale 1ns / 1ps

package sndx_pkg;

    localparam int unsigned ResSlots = 3;

    // phase codes
    localparam logic [1:0] PH_FIRST = 2'd0;
    localparam logic [1:0] PH_HELD  = 2'd1;
    localparam logic [1:0] PH_BODY  = 2'd2;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_P      = 8'h70;
    localparam logic [7:0] CH_UP_P   = 8'h50;
    localparam logic [7:0] CH_H      = 8'h68;
    localparam logic [7:0] CH_UP_H   = 8'h48;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOW_A  = 8'd97;
    localparam logic [7:0] CH_LOW_Z  = 8'd122;

    typedef struct packed {
        logic [1:0] phase;
        logic [7:0] held_first;
        logic       pending_p;
        logic [7:0] last_emitted;
    } sndx_state_t;

    typedef struct packed {
        logic [1:0]                   cnt;
        logic [ResSlots-1:0][7:0]     chars;
        logic [ResSlots-1:0]          lasts;
    } sndx_res_t;

    // Soundex digit of a byte; '0' for vowels and for anything outside a..z.
    function automatic logic [7:0] code_of(input logic [7:0] c);
        logic [7:0] k;
        k = CH_ZERO;
        if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
            case (c)
                8'h62, 8'h66, 8'h70, 8'h76: k = 8'h31;                   // b f p v
                8'h63, 8'h67, 8'h6a, 8'h6b,
                8'h71, 8'h73, 8'h78, 8'h7a: k = 8'h32;                   // c g j k q s x z
                8'h64, 8'h74:               k = 8'h33;                   // d t
                8'h6c:                      k = 8'h34;                   // l
                8'h6d, 8'h6e:               k = 8'h35;                   // m n
                8'h72:                      k = 8'h36;                   // r
                default:                    k = CH_ZERO;
            endcase
        end
        return k;
    endfunction

endpackage

### hdl/sndx_step.sv
// Combinational next-state and result list for one input byte.
`timescale 1ns / 1ps

module sndx_step
    import sndx_pkg::*;
(
    input  logic [7:0]  char_in,
    input  logic        word_end,
    input  sndx_state_t cur,
    output sndx_state_t nxt,
    output sndx_res_t   res
);

    always_comb
    begin
        logic [1:0] n;
        logic [7:0] le;
        logic [7:0] k;
        logic       done;
        sndx_state_t s;

        n    = 2'd0;
        le   = cur.last_emitted;
        s    = cur;
        done = 1'b0;
        k    = CH_ZERO;
        res  = '0;

        if (cur.phase == PH_FIRST) begin
            if (char_in == CH_P || char_in == CH_UP_P) begin
                s.held_first = char_in;
                s.phase      = PH_HELD;
            end else begin
                res.chars[n] = char_in; n = n + 2'd1; le = char_in;
                s.phase      = PH_BODY;
            end
            done = 1'b1;
        end else if (cur.phase == PH_HELD) begin
            s.phase = PH_BODY;
            if (char_in == CH_H || char_in == CH_UP_H) begin
                res.chars[n] = CH_F; n = n + 2'd1; le = CH_F;
                done = 1'b1;
            end else begin
                res.chars[n] = cur.held_first; n = n + 2'd1; le = cur.held_first;
            end
        end

        // body byte handling (also reached from held phase on a non-h follower)
        if (!done) begin
            if (s.pending_p) begin
                s.pending_p = 1'b0;
                if (char_in == CH_H) begin
                    res.chars[n] = CH_ONE; n = n + 2'd1; le = CH_ONE;
                    done = 1'b1;
                end else begin
                    k = code_of(CH_P);
                    if (k != CH_ZERO && k != le) begin
                        res.chars[n] = k; n = n + 2'd1; le = k;
                    end
                end
            end
            if (!done) begin
                if (char_in == CH_P) begin
                    s.pending_p = 1'b1;
                end else begin
                    k = code_of(char_in);
                    if (k != CH_ZERO && k != le) begin
                        res.chars[n] = k; n = n + 2'd1; le = k;
                    end
                end
            end
        end

        s.last_emitted = le;

        if (word_end) begin
            if (s.phase == PH_HELD) begin
                res.chars[n] = s.held_first; n = n + 2'd1; le = s.held_first;
            end
            if (s.pending_p) begin
                k = code_of(CH_P);
                if (k != CH_ZERO && k != le) begin
                    res.chars[n] = k; n = n + 2'd1;
                end
            end
            res.chars[n] = CH_NUL;
            res.lasts[n] = 1'b1;
            n = n + 2'd1;
            s = '0;
        end

        res.cnt = n;
        nxt     = s;
    end

endmodule

### hdl/soundex_phonetic_encoder.sv
// Top level: streaming soundex-style encoder with a three-entry result buffer.
`timescale 1ns / 1ps

// Takes one byte of a word per input transfer (word_end on the last byte) and
// returns the code as a stream of bytes, ending with a NUL result that has
// code_last set. The first result is the first byte copied, or 'f' when the
// word opens with "ph" in any case; later bytes map through the soundex table
// with zero codes and repeats dropped, and a lowercase "ph" in the body gives
// '1'. Rate: each input byte is coded in the cycle it is taken and its zero to
// three results land in a result buffer together; the buffer drains one result
// per cycle while out_ready is high. An input is taken whenever at most one
// result is queued and that one leaves in the same cycle, so with out_ready
// high, bytes with zero or one result flow at one per cycle; a byte giving
// more holds the input while the buffer drains. Results leave straight from
// registers: out_valid, code_char and code_last have no path from out_ready,
// while in_ready follows out_ready combinationally when one result is queued.

module soundex_phonetic_encoder
    import sndx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_in,
    input  logic       word_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] code_char,
    output logic       code_last
);

    // encoder state, updated on every input transfer
    sndx_state_t st_reg;
    sndx_state_t st_next;
    sndx_res_t   step_res;

    // result buffer: loaded whole on an input transfer, drained from the head
    logic [7:0] q_char_reg [ResSlots];
    logic       q_last_reg [ResSlots];
    logic [1:0] q_cnt_reg;
    logic [1:0] q_head_reg;

    logic in_xfer;
    logic out_xfer;

    sndx_step u_step (
        .char_in  (char_in),
        .word_end (word_end),
        .cur      (st_reg),
        .nxt      (st_next),
        .res      (step_res)
    );

    assign out_valid = (q_cnt_reg != 2'd0);
    assign code_char = q_char_reg[q_head_reg];
    assign code_last = q_last_reg[q_head_reg];
    assign out_xfer  = out_valid && out_ready;

    // ready when the buffer is empty or its last entry goes out this cycle
    assign in_ready  = (q_cnt_reg == 2'd0) || (q_cnt_reg == 2'd1 && out_ready);
    assign in_xfer   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg     <= '0;
            q_cnt_reg  <= 2'd0;
            q_head_reg <= 2'd0;
        end else if (in_xfer) begin
            st_reg     <= st_next;
            q_cnt_reg  <= step_res.cnt;
            q_head_reg <= 2'd0;
        end else if (out_xfer) begin
            q_cnt_reg  <= q_cnt_reg - 2'd1;
            q_head_reg <= q_head_reg + 2'd1;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer) begin
            for (int i = 0; i < ResSlots; i++) begin
                q_char_reg[i] <= step_res.chars[i];
                q_last_reg[i] <= step_res.lasts[i];
            end
        end
    end

endmodule

### hdl/sndx_checker.sv
// Port-level checks for the soundex encoder, bound to the top level.
`timescale 1ns / 1ps

module sndx_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] char_in,
    input logic       word_end,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] code_char,
    input logic       code_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_char) && $stable(code_last))
        else $error("result changed while stalled");

    // the last byte of a word always yields at least the terminator
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && word_end |=> out_valid)
        else $error("no result after end of word");

    // terminator carries a NUL byte
    a_term_nul: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && code_last |-> code_char == 8'h00)
        else $error("terminator with nonzero byte");

    // input only stalls while results are queued
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with nothing queued");

endmodule

bind soundex_phonetic_encoder sndx_checker u_sndx_checker (.*);
